[hdl/cbfs_pkg.sv]
`timescale 1ns / 1ps

package cbfs_pkg;

   localparam int STAGE_SLOTS = 4;
   localparam int FIELD_W     = 5;
   localparam int RATE_W      = 32;
   localparam int KIND_W      = 2;
   localparam int WIDTH_W     = 4;
   localparam int OFFSET_W    = 8;
   localparam int STEP_W      = $clog2(STAGE_SLOTS);
   localparam int CNT_W       = $clog2(RATE_W);
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   localparam logic [KIND_W-1:0] KIND_UNITY  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_FIXED  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_LINEAR = 2'd2;
   localparam logic [KIND_W-1:0] KIND_POW2   = 2'd3;

   localparam logic [CSR_INDEX_W-1:0] CSR_KINDS   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_WIDTHS  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_OFFSET0 = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_OFFSET1 = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_OFFSET2 = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_OFFSET3 = 3'd5;

   typedef logic [FIELD_W-1:0] field_type;
   typedef logic [RATE_W-1:0]  rate_type;

   typedef struct packed {
      logic [KIND_W-1:0]   kind;
      logic [OFFSET_W-1:0] offset;
   } stage_cfg_type;

   function automatic field_type field_max(input logic [WIDTH_W-1:0] width);
      logic [WIDTH_W-1:0] sat;
      logic [FIELD_W:0]   span;
      sat  = (width > WIDTH_W'(FIELD_W)) ? WIDTH_W'(FIELD_W) : width;
      span = (FIELD_W+1)'(1) << sat;
      return field_type'(span - (FIELD_W+1)'(1));
   endfunction

endpackage

[hdl/cbfs_factor.sv]
`timescale 1ns / 1ps

module cbfs_factor import cbfs_pkg::*; (
   input  stage_cfg_type cfg,
   input  field_type     value,
   output rate_type      divisor
);

   always_comb begin
      unique case (cfg.kind)
         KIND_UNITY: begin
            divisor = rate_type'(1);
         end
         KIND_FIXED: begin
            divisor = rate_type'(cfg.offset);
         end
         KIND_LINEAR: begin
            divisor = rate_type'(value) + rate_type'(cfg.offset) + rate_type'(1);
         end
         KIND_POW2: begin
            divisor = (rate_type'(1) << value) + rate_type'(cfg.offset);
         end
         default: begin
            divisor = rate_type'(1);
         end
      endcase
   end

endmodule

[hdl/cbfs_divider.sv]
`timescale 1ns / 1ps

module cbfs_divider import cbfs_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   input  rate_type dividend,
   input  rate_type divisor,
   output logic     done,
   output rate_type quotient
);

   logic             run_ff, run_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   rate_type         rem_ff, rem_in;
   rate_type         quo_ff, quo_in;
   rate_type         div_ff, div_in;
   logic [RATE_W:0]  trial;
   logic [RATE_W:0]  diff;
   logic             fits;

   assign trial = {rem_ff, quo_ff[RATE_W-1]};
   assign diff  = trial - {1'b0, div_ff};
   assign fits  = (trial >= {1'b0, div_ff});

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      div_in  = div_ff;
      if (start) begin
         run_in = 1'b1;
         cnt_in = '0;
         rem_in = '0;
         quo_in = dividend;
         div_in = divisor;
      end else if (run_ff) begin
         rem_in = fits ? diff[RATE_W-1:0] : trial[RATE_W-1:0];
         quo_in = {quo_ff[RATE_W-2:0], fits};
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(RATE_W - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

[hdl/clock_divider_best_fit_search_unit.sv]
// Each candidate takes 4 steps on the shared 32x32 multiplier, one per stage; one whose
// divisor is zero or at least 2^32 skips the radix-2 divider, and every other one uses it.
// There are 2^(w0+w1+w2+w3) candidates, widths capped at 5 (at most 2^20), then a report.
// One request at a time; start is ignored and busy stays high until the result strobe.
// The result strobe lasts one cycle and cannot be held off by the receiver.
// Reset is synchronous: it clears the sequencer, the divider control and the configuration.
`timescale 1ns / 1ps

module clock_divider_best_fit_search_unit import cbfs_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [RATE_W-1:0]      req_target_rate,
   input  logic [RATE_W-1:0]      req_parent_rate,
   output logic                   rsp_valid,
   output logic [RATE_W-1:0]      rsp_fit_rate,
   output logic                   rsp_found,
   output logic [FIELD_W-1:0]     rsp_field0_value,
   output logic [FIELD_W-1:0]     rsp_field1_value,
   output logic [FIELD_W-1:0]     rsp_field2_value,
   output logic [FIELD_W-1:0]     rsp_field3_value,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_PROD   = 2'd1;
   localparam logic [1:0] S_DIV    = 2'd2;
   localparam logic [1:0] S_FINISH = 2'd3;

   localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(STAGE_SLOTS - 1);

   logic [KIND_W*STAGE_SLOTS-1:0]  kinds_ff;
   logic [WIDTH_W*STAGE_SLOTS-1:0] widths_ff;
   logic [OFFSET_W-1:0]            offsets_ff [STAGE_SLOTS];

   logic [1:0]        state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   rate_type          prod_ff, prod_in;
   logic              zero_ff, zero_in;
   logic              big_ff, big_in;
   rate_type          target_ff, target_in;
   rate_type          parent_ff, parent_in;
   rate_type          best_ff, best_in;
   field_type         vals_ff [STAGE_SLOTS];
   field_type         vals_in [STAGE_SLOTS];
   field_type         picks_ff [STAGE_SLOTS];
   field_type         picks_in [STAGE_SLOTS];
   logic              rsp_valid_ff, rsp_valid_in;
   rate_type          rsp_best_ff;
   field_type         rsp_picks_ff [STAGE_SLOTS];

   field_type           vals_max [STAGE_SLOTS];
   field_type           vals_next [STAGE_SLOTS];
   logic [STAGE_SLOTS:0] carry;
   logic                advance;

   stage_cfg_type        stage_cfg;
   rate_type             factor;
   logic [2*RATE_W-1:0]  mul_full;
   logic                 div_start;
   logic                 div_done;
   rate_type             quotient;

   always_ff @(posedge clock) begin
      if (reset) begin
         kinds_ff  <= '0;
         widths_ff <= '0;
         for (int s = 0; s < STAGE_SLOTS; s++) begin
            offsets_ff[s] <= '0;
         end
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_KINDS:   kinds_ff      <= csr_wdata[KIND_W*STAGE_SLOTS-1:0];
            CSR_WIDTHS:  widths_ff     <= csr_wdata[WIDTH_W*STAGE_SLOTS-1:0];
            CSR_OFFSET0: offsets_ff[0] <= csr_wdata[OFFSET_W-1:0];
            CSR_OFFSET1: offsets_ff[1] <= csr_wdata[OFFSET_W-1:0];
            CSR_OFFSET2: offsets_ff[2] <= csr_wdata[OFFSET_W-1:0];
            CSR_OFFSET3: offsets_ff[3] <= csr_wdata[OFFSET_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign stage_cfg.kind   = kinds_ff[{step_ff, 1'b0} +: KIND_W];
   assign stage_cfg.offset = offsets_ff[step_ff];

   cbfs_factor u_factor (
      .cfg     (stage_cfg),
      .value   (vals_ff[step_ff]),
      .divisor (factor)
   );

   assign mul_full = (2*RATE_W)'(prod_ff) * (2*RATE_W)'(factor);

   cbfs_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (parent_ff),
      .divisor  (mul_full[RATE_W-1:0]),
      .done     (div_done),
      .quotient (quotient)
   );

   always_comb begin
      carry[0] = 1'b1;
      for (int s = 0; s < STAGE_SLOTS; s++) begin
         vals_max[s]  = field_max(widths_ff[WIDTH_W*s +: WIDTH_W]);
         vals_next[s] = vals_ff[s];
         if (carry[s]) begin
            vals_next[s] = (vals_ff[s] == vals_max[s]) ? '0 : vals_ff[s] + FIELD_W'(1);
         end
         carry[s+1] = carry[s] & (vals_ff[s] == vals_max[s]);
      end
   end

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      prod_in      = prod_ff;
      zero_in      = zero_ff;
      big_in       = big_ff;
      target_in    = target_ff;
      parent_in    = parent_ff;
      best_in      = best_ff;
      vals_in      = vals_ff;
      picks_in     = picks_ff;
      rsp_valid_in = 1'b0;
      div_start    = 1'b0;
      advance      = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               target_in = req_target_rate;
               parent_in = req_parent_rate;
               best_in   = '0;
               for (int s = 0; s < STAGE_SLOTS; s++) begin
                  vals_in[s]  = '0;
                  picks_in[s] = '0;
               end
               prod_in  = rate_type'(1);
               zero_in  = 1'b0;
               big_in   = 1'b0;
               step_in  = '0;
               state_in = S_PROD;
            end
         end
         S_PROD: begin
            prod_in = mul_full[RATE_W-1:0];
            big_in  = big_ff | (mul_full[2*RATE_W-1:RATE_W] != '0);
            zero_in = zero_ff | (factor == '0);
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_LAST) begin
               if (zero_in || big_in) begin
                  advance = 1'b1;
               end else begin
                  div_start = 1'b1;
                  state_in  = S_DIV;
               end
            end
         end
         S_DIV: begin
            if (div_done) begin
               if ((quotient <= target_ff) && (quotient > best_ff)) begin
                  best_in  = quotient;
                  picks_in = vals_ff;
               end
               advance = 1'b1;
            end
         end
         S_FINISH: begin
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      if (advance) begin
         if (carry[STAGE_SLOTS]) begin
            state_in = S_FINISH;
         end else begin
            vals_in  = vals_next;
            prod_in  = rate_type'(1);
            zero_in  = 1'b0;
            big_in   = 1'b0;
            step_in  = '0;
            state_in = S_PROD;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff   <= prod_in;
      zero_ff   <= zero_in;
      big_ff    <= big_in;
      target_ff <= target_in;
      parent_ff <= parent_in;
      best_ff   <= best_in;
      vals_ff   <= vals_in;
      picks_ff  <= picks_in;
      if (rsp_valid_in) begin
         rsp_best_ff  <= best_ff;
         rsp_picks_ff <= picks_ff;
      end
   end

   assign busy             = (state_ff != S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_fit_rate     = rsp_best_ff;
   assign rsp_found        = (rsp_best_ff != '0);
   assign rsp_field0_value = rsp_picks_ff[0];
   assign rsp_field1_value = rsp_picks_ff[1];
   assign rsp_field2_value = rsp_picks_ff[2];
   assign rsp_field3_value = rsp_picks_ff[3];

endmodule

[hdl/cbfs_checker.sv]
`timescale 1ns / 1ps

module cbfs_checker import cbfs_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic              rsp_valid,
   input logic [RATE_W-1:0] rsp_fit_rate,
   input logic              rsp_found
);

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_found == (rsp_fit_rate != '0)))
      else $error("found flag disagrees with fit rate");

   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("request accepted without going busy");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while still searching");

   assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_valid)
      else $error("search ended without a result");

endmodule

bind clock_divider_best_fit_search_unit cbfs_checker u_cbfs_checker (.*);
